// ===== src/hsvck_pkg.sv =====
// Shared constants and types for the HSV colour key with frame difference.
// No dependencies.
package hsvck_pkg;

	localparam int FRAME_PIXELS = 307200;
	localparam bit STROBED      = 1'b1;
	localparam int ADDR_W       = $clog2(FRAME_PIXELS);
	localparam int FIX_SHIFT    = 12;

	typedef enum logic [2:0] {
		REG_HUE_LOW  = 3'd0,
		REG_HUE_HIGH = 3'd1,
		REG_SAT_LOW  = 3'd2,
		REG_SAT_HIGH = 3'd3,
		REG_VAL_LOW  = 3'd4,
		REG_VAL_HIGH = 3'd5,
		REG_THR_LVL  = 3'd6,
		REG_THR_OUT  = 3'd7
	} reg_idx_t;

endpackage

// ===== src/hsv_color_key_strobe_diff.sv =====
// Pixel rate: one pixel per clock, four-stage pipeline from s_axis to the result register;
// the mask store is read in stage 1 and written back in stage 3 (forwarded on a hit).
// A word held on m_axis stalls the whole pipe. The first frame gives no results.
// Store reads are only valid on addresses written in an earlier frame. Uses hsvck_pkg.
module hsv_color_key_strobe_diff (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // blue, green, red
	input  logic        s_axis_tlast,   // end_of_frame
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // mask_pixel
	output logic        m_axis_tlast,   // last_pixel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import hsvck_pkg::*;

	logic [7:0] hue_lo_q, hue_hi_q, sat_lo_q, sat_hi_q, val_lo_q, val_hi_q, thr_lvl_q, thr_out_q;
	logic mem_q [FRAME_PIXELS];
	logic [ADDR_W-1:0] addr_q;
	logic have_prev_q;

	logic adv;
	logic v_s1, v_s2, v_s3;
	logic last_s1, last_s2, last_s3;
	logic [ADDR_W-1:0] addr_s1, addr_s2, addr_s3;
	logic [7:0] mx_s1, diff_s1;
	logic signed [11:0] hs_s1;
	logic emit_s1, emit_s2, emit_s3;
	logic [27:0] sprod_s2;
	logic signed [30:0] hprod_s2;
	logic [7:0] val_s2;
	logic diff0_s2, mx0_s2;
	logic old_s2, keyed_s3, old_s3;
	logic keyed2;

	// rounded reciprocals: round((255 << 12) / mx) and round((180 << 12) / (6 * d))
	wire [19:0] sat_rc [256];
	wire [17:0] hue_rc [256];
	assign sat_rc[0] = '0;
	assign hue_rc[0] = '0;
	for (genvar i = 1; i < 256; i++) begin : g_recip
		localparam logic [19:0] SAT_RC = 20'((2 * (255 << FIX_SHIFT) + i) / (2 * i));
		localparam logic [17:0] HUE_RC = 18'((2 * (180 << FIX_SHIFT) + 6 * i) / (12 * i));
		assign sat_rc[i] = SAT_RC;
		assign hue_rc[i] = HUE_RC;
	end

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_lo_q <= 8'd0; hue_hi_q <= 8'd180;
			sat_lo_q <= 8'd0; sat_hi_q <= 8'd255;
			val_lo_q <= 8'd0; val_hi_q <= 8'd255;
			thr_lvl_q <= 8'd127; thr_out_q <= 8'd255;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_HUE_LOW:  hue_lo_q <= cfg_data;
				REG_HUE_HIGH: hue_hi_q <= cfg_data;
				REG_SAT_LOW:  sat_lo_q <= cfg_data;
				REG_SAT_HIGH: sat_hi_q <= cfg_data;
				REG_VAL_LOW:  val_lo_q <= cfg_data;
				REG_VAL_HIGH: val_hi_q <= cfg_data;
				REG_THR_LVL:  thr_lvl_q <= cfg_data;
				REG_THR_OUT:  thr_out_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipe advances together; output register frees when taken
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	logic [7:0] b, g, r, mx, mn, df;
	logic signed [11:0] hs;
	always_comb begin
		b = s_axis_tdata[7:0]; g = s_axis_tdata[15:8]; r = s_axis_tdata[23:16];
		mx = b; mn = b;
		if (g > mx) mx = g;
		if (r > mx) mx = r;
		if (g < mn) mn = g;
		if (r < mn) mn = r;
		df = mx - mn;
		priority if (mx == r) hs = $signed({4'd0, g}) - $signed({4'd0, b});
		else if (mx == g) hs = $signed({4'd0, b}) - $signed({4'd0, r}) + $signed({3'd0, df, 1'b0});
		else hs = $signed({4'd0, r}) - $signed({4'd0, g}) + $signed({2'd0, df, 2'd0});
	end

	// stage 1: min/max, sector select, store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			addr_q <= '0; have_prev_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid; v_s2 <= v_s1; v_s3 <= v_s2;
			if (s_axis_tvalid) begin
				if (s_axis_tlast) begin
					addr_q <= '0; have_prev_q <= 1'b1;
				end else if (32'(addr_q) + 32'd1 >= 32'(FRAME_PIXELS)) begin
					addr_q <= '0;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
		end
	end

	logic rd_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s1 <= mx; diff_s1 <= df; hs_s1 <= hs;
			last_s1 <= s_axis_tlast; addr_s1 <= addr_q;
			emit_s1 <= !STROBED || have_prev_q;
			rd_s1 <= mem_q[addr_q];
		end
	end

	// stage 2: reciprocal multiplies
	always_ff @(posedge clk) begin
		if (adv) begin
			sprod_s2 <= (mx_s1 == 8'd0) ? 28'd0 : 28'({20'd0, diff_s1} * sat_rc[mx_s1]);
			hprod_s2 <= 31'($signed({{19{hs_s1[11]}}, hs_s1}) *
				$signed({13'd0, hue_rc[diff_s1]}));
			diff0_s2 <= diff_s1 == 8'd0; mx0_s2 <= mx_s1 == 8'd0;
			val_s2 <= mx_s1; last_s2 <= last_s1; addr_s2 <= addr_s1; emit_s2 <= emit_s1;
			// forward a write-back still in flight to the same pixel
			old_s2 <= (v_s2 && addr_s2 == addr_s1) ? keyed2 :
				(v_s3 && addr_s3 == addr_s1) ? keyed_s3 : rd_s1;
		end
	end

	logic [8:0] sat2;
	logic signed [31:0] hr;
	logic [7:0] hue2;
	always_comb begin
		sat2 = 9'((sprod_s2 + 28'd2048) >> FIX_SHIFT);
		hr = ($signed({hprod_s2[30], hprod_s2}) + 32'sd2048) >>> FIX_SHIFT;
		if (diff0_s2) hue2 = 8'd0;
		else if (hr < 0) hue2 = 8'(hr + 32'sd180);
		else hue2 = 8'(hr);
		if (mx0_s2) sat2 = 9'd0;
		keyed2 = hue2 >= hue_lo_q && hue2 <= hue_hi_q &&
			sat2[7:0] >= sat_lo_q && sat2[7:0] <= sat_hi_q &&
			val_s2 >= val_lo_q && val_s2 <= val_hi_q;
	end

	// stage 3: key, write back
	always_ff @(posedge clk) begin
		if (adv) begin
			keyed_s3 <= keyed2; old_s3 <= old_s2;
			last_s3 <= last_s2; addr_s3 <= addr_s2; emit_s3 <= emit_s2;
			if (v_s2) mem_q[addr_s2] <= keyed2;
		end
	end

	logic pass;
	assign pass = ((STROBED ? (keyed_s3 != old_s3) : keyed_s3) ? 8'd255 : 8'd0) > thr_lvl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= v_s3 && emit_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= pass ? thr_out_q : 8'd0;
			m_axis_tlast <= last_s3;
		end
	end
endmodule

// ===== src/hsvck_checker.sv =====
// Port-level checks for hsv_color_key_strobe_diff, bound to the top level.
// Uses no package.
module hsvck_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       cfg_ready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("word dropped under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready) else $error("input stalled with empty output");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port blocked");
	a_rst: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("word out of reset");
endmodule

bind hsv_color_key_strobe_diff hsvck_checker u_chk (.*);
